// ===== hw/rtl/cerkn_pkg.sv =====
// shared types and constants for the convolutional encoder block
// no dependencies; compile before all other files
package cerkn_pkg;

   localparam int BYTE_WIDTH      = 8;
   localparam int GEN_WIDTH       = 7;
   localparam int SYMBOL_WIDTH    = 4;
   localparam int NUM_GENS        = 4;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam int DEF_BITS_PER_STEP  = 1;
   localparam int DEF_CONSTRAINT_LEN = 7;
   localparam int DEF_OUTPUTS        = 2;
   localparam int DEF_TAIL_STEPS     = 6;

   localparam logic [GEN_WIDTH-1:0] GEN_RESET [NUM_GENS] = '{7'd121, 7'd91, 7'd0, 7'd0};

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GEN_POLY_0 = 2'd0,
      CSR_GEN_POLY_1 = 2'd1,
      CSR_GEN_POLY_2 = 2'd2,
      CSR_GEN_POLY_3 = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DATA,
      ST_TAIL
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic tail;
      logic last;
      logic clear;
   } dp_cmd_type;

   typedef struct packed {
      logic last_chunk;
      logic eop;
   } dp_status_type;

endpackage

// ===== hw/rtl/cerkn_chan_if.sv =====
// valid/ready channel interfaces for request and response beats
// depends on cerkn_pkg
interface cerkn_req_if import cerkn_pkg::*; ;
   logic                  valid;
   logic                  ready;
   logic [BYTE_WIDTH-1:0] data_byte;
   logic                  end_of_packet;

   modport source (output valid, output data_byte, output end_of_packet, input ready);
   modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

interface cerkn_rsp_if import cerkn_pkg::*; ;
   logic                    valid;
   logic                    ready;
   logic [SYMBOL_WIDTH-1:0] coded_symbol;
   logic                    last_of_run;
   logic                    leftover_error;

   modport source (output valid, output coded_symbol, output last_of_run,
                   output leftover_error, input ready);
   modport sink (input valid, input coded_symbol, input last_of_run,
                 input leftover_error, output ready);
endinterface

// ===== hw/rtl/cerkn_datapath.sv =====
// encoder datapath: generator registers, bit stream, delay line, symbol register
// depends on cerkn_pkg; driven by cerkn_ctrl
module cerkn_datapath import cerkn_pkg::*; #(
   parameter int BITS_PER_STEP  = DEF_BITS_PER_STEP,
   parameter int CONSTRAINT_LEN = DEF_CONSTRAINT_LEN,
   parameter int OUTPUTS        = DEF_OUTPUTS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [GEN_WIDTH-1:0]       csr_wr_data,
   input  logic [BYTE_WIDTH-1:0]      data_byte,
   input  logic                       end_of_packet,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   output logic [SYMBOL_WIDTH-1:0]    coded_symbol,
   output logic                       last_of_run,
   output logic                       leftover_error
);

   localparam int DLW = BITS_PER_STEP * CONSTRAINT_LEN;
   localparam int SW  = BYTE_WIDTH + BITS_PER_STEP - 1;
   localparam int CW  = $clog2(SW + 1);
   localparam int PW  = DLW + GEN_WIDTH;

   // leftover count after a byte, indexed by bits available
   localparam logic [2:0] REM_LUT [16] = '{
      3'(0 % BITS_PER_STEP),  3'(1 % BITS_PER_STEP),  3'(2 % BITS_PER_STEP),
      3'(3 % BITS_PER_STEP),  3'(4 % BITS_PER_STEP),  3'(5 % BITS_PER_STEP),
      3'(6 % BITS_PER_STEP),  3'(7 % BITS_PER_STEP),  3'(8 % BITS_PER_STEP),
      3'(9 % BITS_PER_STEP),  3'(10 % BITS_PER_STEP), 3'(11 % BITS_PER_STEP),
      3'(12 % BITS_PER_STEP), 3'(13 % BITS_PER_STEP), 3'(14 % BITS_PER_STEP),
      3'(15 % BITS_PER_STEP)
   };

   logic [GEN_WIDTH-1:0]    gen_ff [NUM_GENS];
   logic [SW-1:0]           stream_ff;
   logic [CW-1:0]           cnt_ff;
   logic [DLW-1:0]          dl_ff;
   logic                    eop_ff;
   logic                    err_ff;
   logic [SYMBOL_WIDTH-1:0] sym_ff;
   logic                    last_ff;
   logic                    lerr_ff;

   logic [BITS_PER_STEP-1:0] chunk;
   logic [BITS_PER_STEP-1:0] shift_bits;
   logic [DLW-1:0]           dl_in;
   logic [CW-1:0]            cnt_load;
   logic [PW-1:0]            gen_pad [NUM_GENS];
   logic [DLW-1:0]           rev_poly [NUM_GENS];
   logic [SYMBOL_WIDTH-1:0]  sym_in;

   always_comb begin
      chunk      = BITS_PER_STEP'(stream_ff >> (cnt_ff - CW'(BITS_PER_STEP)));
      shift_bits = cmd.tail ? '0 : chunk;
      dl_in      = DLW'({dl_ff, shift_bits});
      cnt_load   = cnt_ff + CW'(BYTE_WIDTH);
      for (int j = 0; j < NUM_GENS; j++) begin
         gen_pad[j] = PW'(gen_ff[j]);
         for (int i = 0; i < DLW; i++) begin
            rev_poly[j][DLW-1-i] = gen_pad[j][i];
         end
         sym_in[j] = (j < OUTPUTS) ? ^(dl_in & rev_poly[j]) : 1'b0;
      end
   end

   // generator registers and encoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_GENS; j++) begin
            gen_ff[j] <= GEN_RESET[j];
         end
         cnt_ff <= '0;
         dl_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_index))
               CSR_GEN_POLY_0: gen_ff[0] <= csr_wr_data;
               CSR_GEN_POLY_1: gen_ff[1] <= csr_wr_data;
               CSR_GEN_POLY_2: gen_ff[2] <= csr_wr_data;
               CSR_GEN_POLY_3: gen_ff[3] <= csr_wr_data;
               default: ;
            endcase
         end
         if (cmd.clear) begin
            dl_ff  <= '0;
            cnt_ff <= '0;
         end else if (cmd.load) begin
            cnt_ff <= cnt_load;
         end else if (cmd.step) begin
            dl_ff <= dl_in;
            if (!cmd.tail) begin
               cnt_ff <= cnt_ff - CW'(BITS_PER_STEP);
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         stream_ff <= (stream_ff << BYTE_WIDTH) | SW'(data_byte);
         eop_ff    <= end_of_packet;
         err_ff    <= end_of_packet && (REM_LUT[cnt_load] != 3'd0);
      end
      if (cmd.step) begin
         sym_ff  <= sym_in;
         last_ff <= cmd.last;
         lerr_ff <= err_ff;
      end
   end

   assign status.last_chunk = cnt_ff < CW'(2 * BITS_PER_STEP);
   assign status.eop        = eop_ff;
   assign coded_symbol      = sym_ff;
   assign last_of_run       = last_ff;
   assign leftover_error    = lerr_ff;

   a_step_has_bits: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && !cmd.tail) |-> (cnt_ff >= CW'(BITS_PER_STEP)))
      else $error("data step without a full chunk");

   a_load_leftover_small: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (cnt_ff < CW'(BITS_PER_STEP)))
      else $error("byte loaded while a full chunk remains");

endmodule

// ===== hw/rtl/cerkn_ctrl.sv =====
// encoder controller: accepts a byte, sequences data and tail steps, owns rsp valid
// depends on cerkn_pkg; drives cerkn_datapath
module cerkn_ctrl import cerkn_pkg::*; #(
   parameter int TAIL_STEPS = DEF_TAIL_STEPS
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int TW        = (TAIL_STEPS > 1) ? $clog2(TAIL_STEPS) : 1;
   localparam int TAIL_LAST = (TAIL_STEPS > 0) ? TAIL_STEPS - 1 : 0;

   state_type       state_ff, state_in;
   logic [TW-1:0]   tail_cnt_ff, tail_cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tail_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tail_cnt_ff  <= tail_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      cmd         = '0;
      state_in    = state_ff;
      tail_cnt_in = tail_cnt_ff;
      req_ready   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (out_free) begin
               cmd.step = 1'b1;
               if (status.last_chunk) begin
                  if (status.eop && (TAIL_STEPS > 0)) begin
                     tail_cnt_in = '0;
                     state_in    = ST_TAIL;
                  end else begin
                     cmd.last  = 1'b1;
                     cmd.clear = status.eop;
                     state_in  = ST_IDLE;
                  end
               end
            end
         end
         ST_TAIL: begin
            if (out_free) begin
               cmd.step = 1'b1;
               cmd.tail = 1'b1;
               if (tail_cnt_ff == TW'(TAIL_LAST)) begin
                  cmd.last  = 1'b1;
                  cmd.clear = 1'b1;
                  state_in  = ST_IDLE;
               end else begin
                  tail_cnt_in = tail_cnt_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.step ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_valid = rsp_valid_ff;

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && cmd.last) |=> (state_ff == ST_IDLE))
      else $error("run did not end after its last beat");

   a_tail_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TAIL) |-> (tail_cnt_ff <= TW'(TAIL_LAST)))
      else $error("tail counter past its last step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.step)
      else $error("symbol register overwritten while a beat waits");

endmodule

// ===== hw/rtl/conv_encoder_rate_k_n_unit.sv =====
// top level of the convolutional encoder: controller plus datapath
// depends on cerkn_pkg, cerkn_chan_if, cerkn_ctrl, cerkn_datapath
//
//   channel | dir | handshake          | payload
//   req     | in  | valid / ready      | data_byte[7:0], end_of_packet
//   rsp     | out | valid / ready      | coded_symbol[3:0], last_of_run, leftover_error
//   csr     | in  | csr_wr_en          | csr_index[1:0], csr_wr_data[6:0]
//
// a byte is accepted, then takes (leftover + 8) / BITS_PER_STEP data steps,
// plus TAIL_STEPS steps when it ends a packet; one step per cycle while rsp is not stalled
// the step rate is set by the single delay line update and the symbol register
// reset clears state, delay line and leftovers and loads generator defaults
// a stalled rsp holds the step sequence; req is taken only between bytes
module conv_encoder_rate_k_n_unit import cerkn_pkg::*; #(
   parameter int BITS_PER_STEP  = DEF_BITS_PER_STEP,
   parameter int CONSTRAINT_LEN = DEF_CONSTRAINT_LEN,
   parameter int OUTPUTS        = DEF_OUTPUTS,
   parameter int TAIL_STEPS     = DEF_TAIL_STEPS
) (
   input  logic                       clock,
   input  logic                       reset,
   cerkn_req_if.sink                  req_chan,
   cerkn_rsp_if.source                rsp_chan,
   input  logic                       csr_wr_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [GEN_WIDTH-1:0]       csr_wr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   cerkn_ctrl #(
      .TAIL_STEPS (TAIL_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cerkn_datapath #(
      .BITS_PER_STEP  (BITS_PER_STEP),
      .CONSTRAINT_LEN (CONSTRAINT_LEN),
      .OUTPUTS        (OUTPUTS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .data_byte      (req_chan.data_byte),
      .end_of_packet  (req_chan.end_of_packet),
      .cmd            (cmd),
      .status         (status),
      .coded_symbol   (rsp_chan.coded_symbol),
      .last_of_run    (rsp_chan.last_of_run),
      .leftover_error (rsp_chan.leftover_error)
   );

endmodule
